// ===== hdl/yuv420_to_yuv422_rotate_core_assert.svh =====
// Assertion macros for the 4:2:0 to 4:2:2 rotate core.
// Depends on a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef YUV420_TO_YUV422_ROTATE_CORE_ASSERT_SVH
`define YUV420_TO_YUV422_ROTATE_CORE_ASSERT_SVH

// Plain clocked property, quiet during reset.
`define YR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define YR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/yuvrot_pkg.sv =====
// Shared widths, codes and reset values for the 4:2:0 to 4:2:2 rotate core.
// No dependencies; used by the channel interfaces and the core.
package yuvrot_pkg;

  // Field widths fixed by the data formats.
  localparam int unsigned SizeW    = 12;
  localparam int unsigned AddrW    = 21;
  localparam int unsigned PixW     = 8;
  localparam int unsigned WordW    = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;
  localparam int unsigned RotW     = 2;
  localparam int unsigned PackW    = 2;

  // Default largest frame dimension in pixels.
  localparam int unsigned MaxDimDefault = 2048;

  // Register reset values.
  localparam logic [SizeW-1:0] SrcWidthRst  = 12'd176;
  localparam logic [SizeW-1:0] SrcHeightRst = 12'd144;
  localparam logic [SizeW-1:0] DstPitchRst  = 12'd176;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SRC_WIDTH  = 3'd0,
    CFG_SRC_HEIGHT = 3'd1,
    CFG_DST_PITCH  = 3'd2,
    CFG_ROTATION   = 3'd3,
    CFG_PACK_ORDER = 3'd4
  } cfg_idx_e;

  // Rotation codes.
  typedef enum logic [RotW-1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_e;

  // Byte orders, named by bytes 0..3; the unused code behaves as U,Ya,V,Yb.
  typedef enum logic [PackW-1:0] {
    PACK_U_YA_V_YB = 2'd0,
    PACK_YB_V_YA_U = 2'd1,
    PACK_YA_V_YB_U = 2'd2
  } pack_e;

  typedef logic [PixW-1:0]  pix_t;
  typedef logic [AddrW-1:0] addr_t;
  typedef logic [WordW-1:0] word_t;

endpackage

// ===== hdl/yuvrot_if.sv =====
// Valid/ready channel interfaces for block requests and packed word results.
// Depends on yuvrot_pkg for the field types.
interface yuvrot_in_if import yuvrot_pkg::*; ();
  logic valid;
  logic ready;
  pix_t luma_top_left;
  pix_t luma_top_right;
  pix_t luma_bottom_left;
  pix_t luma_bottom_right;
  pix_t chroma_blue;
  pix_t chroma_red;

  modport source (
    output valid, luma_top_left, luma_top_right, luma_bottom_left,
           luma_bottom_right, chroma_blue, chroma_red,
    input  ready
  );
  modport sink (
    input  valid, luma_top_left, luma_top_right, luma_bottom_left,
           luma_bottom_right, chroma_blue, chroma_red,
    output ready
  );
endinterface

interface yuvrot_out_if import yuvrot_pkg::*; ();
  logic  valid;
  logic  ready;
  addr_t word_address;
  word_t packed_word;
  logic  second_of_pair;
  logic  frame_done;

  modport source (
    output valid, word_address, packed_word, second_of_pair, frame_done,
    input  ready
  );
  modport sink (
    input  valid, word_address, packed_word, second_of_pair, frame_done,
    output ready
  );
endinterface

// ===== hdl/yuv420_to_yuv422_rotate_core.sv =====
// A request accepted at edge N shows its first word after edge N and its
// second word after the first is taken. A new request waits until the second word
// of the last block is leaving, set by the single result port that carries the
// two words of a block one after the other.
// Reset clears the counters, loads the register defaults and starts a new frame;
// a register write restarts the frame and holds off requests in the cycle after the write.
// Depends on yuvrot_pkg, yuvrot_if and yuv420_to_yuv422_rotate_core_assert.svh.
`include "yuv420_to_yuv422_rotate_core_assert.svh"

module yuv420_to_yuv422_rotate_core import yuvrot_pkg::*; #(
  parameter int unsigned MAX_DIMENSION = MaxDimDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  yuvrot_in_if.sink           in_i,
  yuvrot_out_if.source        out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned MaxPairs = MAX_DIMENSION / 2;
  localparam int unsigned CntW     = $clog2(MaxPairs);
  localparam int unsigned PairW    = CntW + 1;
  localparam int unsigned MulBW    = PairW + 1;
  localparam int unsigned HpW      = SizeW - 1;
  localparam int unsigned ProdW    = HpW + MulBW;

  typedef enum logic [1:0] {
    OB_EMPTY,
    OB_FIRST,
    OB_SECOND
  } obuf_e;

  // Pair count of a size: halved, at least one, at most half the maximum.
  function automatic logic [PairW-1:0] pair_count(logic [SizeW-1:0] size);
    logic [SizeW-1:0] raw;
    raw = {1'b0, size[SizeW-1:1]};
    if (raw == '0) begin
      return PairW'(1);
    end else if (32'(raw) > 32'(MaxPairs)) begin
      return PairW'(MaxPairs);
    end else begin
      return PairW'(raw);
    end
  endfunction

  // Byte packing of two pixels with their shared chroma.
  function automatic word_t pack(pix_t ya, pix_t yb, pix_t u, pix_t v, pack_e order);
    word_t w;
    unique case (order)
      PACK_YB_V_YA_U: w = {u, ya, v, yb};
      PACK_YA_V_YB_U: w = {u, yb, v, ya};
      default:        w = {yb, v, ya, u};
    endcase
    return w;
  endfunction

  // Configuration registers.
  logic [SizeW-1:0] src_width_q, src_height_q, dst_pitch_q;
  rot_e             rotation_q;
  pack_e            pack_order_q;

  // Frame walk state.
  logic [CntW-1:0] column_pair_q, row_pair_q;
  addr_t           row_base_q, block_q, start_q;
  logic            fresh_q, settle_q;

  // Output buffer holding both words of one block.
  obuf_e obuf_q;
  addr_t addr1_q, addr2_q;
  word_t word1_q, word2_q;
  logic  done_q;

  logic [PairW-1:0] col_pairs, row_pairs;
  logic [HpW-1:0]   hp;
  logic [MulBW-1:0] mul_b;
  logic [ProdW-1:0] prod;
  addr_t            start_d;
  addr_t            cur_a, cur_rb, a2, col_step, row_step, hp_a, dp_a;
  word_t            w1, w2;
  logic             col_wrap, row_wrap;
  logic             in_fire, out_fire, cfg_restart;

  assign col_pairs = pair_count(src_width_q);
  assign row_pairs = pair_count(src_height_q);
  assign hp        = dst_pitch_q[SizeW-1:1];
  assign hp_a      = AddrW'(hp);
  assign dp_a      = AddrW'({hp, 1'b0});

  // Start address of a frame; one multiply, registered every cycle.
  always_comb begin
    mul_b = (rotation_q == ROT_90) ? MulBW'({col_pairs, 1'b0} - 1'b1)
                                   : MulBW'({row_pairs, 1'b0});
    prod  = ProdW'(hp) * ProdW'(mul_b);
    unique case (rotation_q)
      ROT_90:  start_d = AddrW'(prod);
      ROT_180: start_d = AddrW'(prod) - AddrW'(1);
      ROT_270: start_d = AddrW'(row_pairs) - AddrW'(1);
      default: start_d = '0;
    endcase
  end

  // Word addresses, pixel order and address steps for the current block.
  always_comb begin
    cur_a  = fresh_q ? start_q : block_q;
    cur_rb = fresh_q ? start_q : row_base_q;
    unique case (rotation_q)
      ROT_90: begin
        w1 = pack(in_i.luma_top_left, in_i.luma_bottom_left,
                  in_i.chroma_blue, in_i.chroma_red, pack_order_q);
        w2 = pack(in_i.luma_top_right, in_i.luma_bottom_right,
                  in_i.chroma_blue, in_i.chroma_red, pack_order_q);
        a2       = cur_a - hp_a;
        col_step = '0 - dp_a;
        row_step = AddrW'(1);
      end
      ROT_180: begin
        w1 = pack(in_i.luma_top_right, in_i.luma_top_left,
                  in_i.chroma_blue, in_i.chroma_red, pack_order_q);
        w2 = pack(in_i.luma_bottom_right, in_i.luma_bottom_left,
                  in_i.chroma_blue, in_i.chroma_red, pack_order_q);
        a2       = cur_a - hp_a;
        col_step = '1;
        row_step = '0 - dp_a;
      end
      ROT_270: begin
        w1 = pack(in_i.luma_bottom_left, in_i.luma_top_left,
                  in_i.chroma_blue, in_i.chroma_red, pack_order_q);
        w2 = pack(in_i.luma_bottom_right, in_i.luma_top_right,
                  in_i.chroma_blue, in_i.chroma_red, pack_order_q);
        a2       = cur_a + hp_a;
        col_step = dp_a;
        row_step = '1;
      end
      default: begin
        w1 = pack(in_i.luma_top_left, in_i.luma_top_right,
                  in_i.chroma_blue, in_i.chroma_red, pack_order_q);
        w2 = pack(in_i.luma_bottom_left, in_i.luma_bottom_right,
                  in_i.chroma_blue, in_i.chroma_red, pack_order_q);
        a2       = cur_a + hp_a;
        col_step = AddrW'(1);
        row_step = dp_a;
      end
    endcase
    col_wrap = (PairW'(column_pair_q) + PairW'(1)) >= col_pairs;
    row_wrap = (PairW'(row_pair_q) + PairW'(1)) >= row_pairs;
  end

  // Handshakes: a block enters an empty buffer or as the last block's second word leaves.
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_fire    = out_o.valid && out_o.ready;
  assign cfg_restart = cfg_we_i && (cfg_index_i <= CFG_PACK_ORDER);
  assign in_i.ready  = !settle_q &&
                       ((obuf_q == OB_EMPTY) || ((obuf_q == OB_SECOND) && out_o.ready));

  // Control state: configuration, frame walk and output buffer occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q   <= SrcWidthRst;
      src_height_q  <= SrcHeightRst;
      dst_pitch_q   <= DstPitchRst;
      rotation_q    <= ROT_0;
      pack_order_q  <= PACK_U_YA_V_YB;
      column_pair_q <= '0;
      row_pair_q    <= '0;
      row_base_q    <= '0;
      block_q       <= '0;
      start_q       <= '0;
      fresh_q       <= 1'b1;
      settle_q      <= 1'b0;
      obuf_q        <= OB_EMPTY;
    end else begin
      start_q  <= start_d;
      settle_q <= 1'b0;

      // Walk the blocks of the frame.
      if (in_fire) begin
        fresh_q <= 1'b0;
        if (col_wrap) begin
          if (row_wrap) begin
            column_pair_q <= '0;
            row_pair_q    <= '0;
            fresh_q       <= 1'b1;
          end else begin
            column_pair_q <= '0;
            row_pair_q    <= row_pair_q + 1'b1;
            row_base_q    <= cur_rb + row_step;
            block_q       <= cur_rb + row_step;
          end
        end else begin
          column_pair_q <= column_pair_q + 1'b1;
          row_base_q    <= cur_rb;
          block_q       <= cur_a + col_step;
        end
      end

      // Register writes restart the frame and hold off requests while the start address settles.
      if (cfg_restart) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_SRC_WIDTH:  src_width_q  <= cfg_data_i[SizeW-1:0];
          CFG_SRC_HEIGHT: src_height_q <= cfg_data_i[SizeW-1:0];
          CFG_DST_PITCH:  dst_pitch_q  <= cfg_data_i[SizeW-1:0];
          CFG_ROTATION:   rotation_q   <= rot_e'(cfg_data_i[RotW-1:0]);
          default:        pack_order_q <= pack_e'(cfg_data_i[PackW-1:0]);
        endcase
        column_pair_q <= '0;
        row_pair_q    <= '0;
        fresh_q       <= 1'b1;
        settle_q      <= 1'b1;
      end

      // Output buffer sequencing.
      if (in_fire) begin
        obuf_q <= OB_FIRST;
      end else if (out_fire) begin
        obuf_q <= (obuf_q == OB_FIRST) ? OB_SECOND : OB_EMPTY;
      end
    end
  end

  // Result payload, loaded when a request is accepted.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      addr1_q <= cur_a;
      addr2_q <= a2;
      word1_q <= w1;
      word2_q <= w2;
      done_q  <= col_wrap && row_wrap;
    end
  end

  // Result port shows the first word, then the second.
  assign out_o.valid          = (obuf_q != OB_EMPTY);
  assign out_o.second_of_pair = (obuf_q == OB_SECOND);
  assign out_o.word_address   = (obuf_q == OB_SECOND) ? addr2_q : addr1_q;
  assign out_o.packed_word    = (obuf_q == OB_SECOND) ? word2_q : word1_q;
  assign out_o.frame_done     = (obuf_q == OB_SECOND) && done_q;

  `YR_ASSERT_NEXT(a_accept_shows_first, in_fire,
                  out_o.valid && !out_o.second_of_pair,
                  "accepted request did not show its first word")
  `YR_ASSERT_NEXT(a_first_then_second, out_fire && !out_o.second_of_pair,
                  out_o.valid && out_o.second_of_pair,
                  "second word did not follow the first")
  `YR_ASSERT(a_done_on_second, (out_o.valid && out_o.frame_done) |-> out_o.second_of_pair,
             "frame end flagged on a first word")
  `YR_ASSERT_NEXT(a_cfg_holds_input, cfg_restart, !in_i.ready,
                  "request taken before the start address settled")

endmodule

// ===== sim/yuv420_to_yuv422_rotate_checker.sv =====
// Checker for the 4:2:0 to 4:2:2 rotate core: predicts the packed words of each block
// request and compares them with the result channel. Depends on yuvrot_pkg and yuvrot_if.
module yuv420_to_yuv422_rotate_checker import yuvrot_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  yuvrot_in_if                blocks_i,
  yuvrot_out_if               words_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    addr_t address;
    word_t data;
    logic  second;
    logic  done;
  } word_rec_t;

  // Shadow copy of the registers and the frame walk.
  logic [SizeW-1:0] frame_w;
  logic [SizeW-1:0] frame_h;
  logic [SizeW-1:0] out_pitch;
  rot_e             turn;
  logic [PackW-1:0] byte_order;
  int unsigned      col_count;
  int unsigned      row_count;
  addr_t            row_addr;
  addr_t            cur_addr;

  word_rec_t expected_words[$];
  int        mismatches;

  // Pairs in one dimension; odd sizes round down and the count is clamped.
  function automatic int unsigned pair_total(logic [SizeW-1:0] size);
    int unsigned n;
    n = size >> 1;
    if (n < 1) n = 1;
    if (n > MaxDimDefault / 2) n = MaxDimDefault / 2;
    return n;
  endfunction

  // Back to the first block, at the corner that the rotation starts from.
  function automatic void restart_frame();
    int unsigned hp;
    int unsigned start;
    hp = out_pitch >> 1;
    case (turn)
      ROT_90:  start = hp * (2 * pair_total(frame_w) - 1);
      ROT_180: start = 2 * hp * pair_total(frame_h) - 1;
      ROT_270: start = pair_total(frame_h) - 1;
      default: start = 0;
    endcase
    col_count = 0;
    row_count = 0;
    row_addr  = addr_t'(start);
    cur_addr  = row_addr;
  endfunction

  // Little-endian byte placement of two pixels and the shared chroma.
  function automatic word_t pack_pixels(pix_t ya, pix_t yb, pix_t u, pix_t v);
    case (byte_order)
      PACK_YB_V_YA_U: return {u, ya, v, yb};
      PACK_YA_V_YB_U: return {u, yb, v, ya};
      default:        return {yb, v, ya, u};
    endcase
  endfunction

  // Queue the two words of the block on the request channel and step the frame walk.
  function automatic void convert_block();
    pix_t        tl, tr, bl, br, cb, cr;
    int unsigned hp;
    addr_t       first, second, col_step, row_step;
    word_t       w1, w2;
    logic        last;
    tl = blocks_i.luma_top_left;
    tr = blocks_i.luma_top_right;
    bl = blocks_i.luma_bottom_left;
    br = blocks_i.luma_bottom_right;
    cb = blocks_i.chroma_blue;
    cr = blocks_i.chroma_red;
    hp = out_pitch >> 1;
    first = cur_addr;
    case (turn)
      ROT_90: begin
        w1 = pack_pixels(tl, bl, cb, cr);
        w2 = pack_pixels(tr, br, cb, cr);
        second   = first - addr_t'(hp);
        col_step = addr_t'(0) - addr_t'(2 * hp);
        row_step = addr_t'(1);
      end
      ROT_180: begin
        w1 = pack_pixels(tr, tl, cb, cr);
        w2 = pack_pixels(br, bl, cb, cr);
        second   = first - addr_t'(hp);
        col_step = '1;
        row_step = addr_t'(0) - addr_t'(2 * hp);
      end
      ROT_270: begin
        w1 = pack_pixels(bl, tl, cb, cr);
        w2 = pack_pixels(br, tr, cb, cr);
        second   = first + addr_t'(hp);
        col_step = addr_t'(2 * hp);
        row_step = '1;
      end
      default: begin
        w1 = pack_pixels(tl, tr, cb, cr);
        w2 = pack_pixels(bl, br, cb, cr);
        second   = first + addr_t'(hp);
        col_step = addr_t'(1);
        row_step = addr_t'(2 * hp);
      end
    endcase

    // The last block of the frame wraps the walk back to its start.
    last = 1'b0;
    if (col_count + 1 >= pair_total(frame_w)) begin
      if (row_count + 1 >= pair_total(frame_h)) begin
        last = 1'b1;
        restart_frame();
      end else begin
        col_count = 0;
        row_count++;
        row_addr = row_addr + row_step;
        cur_addr = row_addr;
      end
    end else begin
      col_count++;
      cur_addr = cur_addr + col_step;
    end

    expected_words.push_back('{first, w1, 1'b0, 1'b0});
    expected_words.push_back('{second, w2, 1'b1, last});
  endfunction

  // Track register writes, predict on each request and compare each word taken.
  always @(posedge clk_i or negedge rst_ni) begin
    word_rec_t want;
    if (!rst_ni) begin
      frame_w    = SrcWidthRst;
      frame_h    = SrcHeightRst;
      out_pitch  = DstPitchRst;
      turn       = ROT_0;
      byte_order = PACK_U_YA_V_YB;
      restart_frame();
      expected_words.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_SRC_WIDTH:  frame_w    = cfg_data_i;
          CFG_SRC_HEIGHT: frame_h    = cfg_data_i;
          CFG_DST_PITCH:  out_pitch  = cfg_data_i;
          CFG_ROTATION:   turn       = rot_e'(cfg_data_i[RotW-1:0]);
          CFG_PACK_ORDER: byte_order = cfg_data_i[PackW-1:0];
          default: ;
        endcase
        // Any known register restarts the frame.
        if (cfg_index_i <= CFG_PACK_ORDER) restart_frame();
      end

      if (blocks_i.valid && blocks_i.ready) convert_block();

      if (words_i.valid && words_i.ready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected packed word at word_address %h", words_i.word_address);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          if (words_i.word_address !== want.address) begin
            $error("word_address: expected %h, actual %h", want.address, words_i.word_address);
            mismatches++;
          end
          if (words_i.packed_word !== want.data) begin
            $error("packed_word: expected %h, actual %h", want.data, words_i.packed_word);
            mismatches++;
          end
          if (words_i.second_of_pair !== want.second) begin
            $error("second_of_pair: expected %b, actual %b", want.second,
                   words_i.second_of_pair);
            mismatches++;
          end
          if (words_i.frame_done !== want.done) begin
            $error("frame_done: expected %b, actual %b", want.done, words_i.frame_done);
            mismatches++;
          end
        end
      end

      fail_count_o <= mismatches;
      pending_o    <= expected_words.size();
    end
  end

endmodule

// ===== sim/yuv420_to_yuv422_rotate_core_test.sv =====
// Top of the rotate core testbench: clock, reset, register setup, block requests and
// result backpressure. Depends on yuvrot_pkg, yuvrot_if, the core and its checker.
module yuv420_to_yuv422_rotate_core_test import yuvrot_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumItems  = 1050;
  localparam int IdleLimit = 2000;
  localparam int LongStall = 300;
  localparam int Drain     = 10;

  // The spare byte order code, which the core treats as the first one.
  localparam logic [PackW-1:0] PackUnused = 2'd3;

  // Pixels of one request: top left, top right, bottom left, bottom right, Cb, Cr.
  typedef logic [5:0][PixW-1:0] block_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  int                  fail_count;
  int                  pending;
  int                  burst_left = 0;
  bit                  stall_now = 1'b0;
  bit                  stall_done = 1'b0;
  int                  idle_cycles;

  yuvrot_in_if  blocks_if ();
  yuvrot_out_if words_if ();

  yuv420_to_yuv422_rotate_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (blocks_if),
    .out_o       (words_if),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  yuv420_to_yuv422_rotate_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .blocks_i     (blocks_if),
    .words_i      (words_if),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #4ns clk_i = ~clk_i;

  // Random pixels with a fair share of the extremes.
  function automatic block_t random_block();
    block_t b;
    for (int i = 0; i < 6; i++) begin
      case ($urandom_range(0, 15))
        0:       b[i] = '0;
        1:       b[i] = '1;
        default: b[i] = PixW'($urandom);
      endcase
    end
    return b;
  endfunction

  // A size register value that gives the wanted pair count, odd or clamped at times.
  function automatic logic [SizeW-1:0] size_for(int pairs);
    if (pairs == 1 && $urandom_range(0, 3) == 0) return SizeW'($urandom_range(0, 1));
    if (pairs >= MaxDimDefault / 2)
      return SizeW'($urandom_range(MaxDimDefault, (1 << SizeW) - 1));
    return SizeW'(2 * pairs + $urandom_range(0, 1));
  endfunction

  // Offer one block request in bursts with random gaps and hold it until taken.
  task automatic offer(input block_t b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        blocks_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    blocks_if.valid             <= 1'b1;
    blocks_if.luma_top_left     <= b[0];
    blocks_if.luma_top_right    <= b[1];
    blocks_if.luma_bottom_left  <= b[2];
    blocks_if.luma_bottom_right <= b[3];
    blocks_if.chroma_blue       <= b[4];
    blocks_if.chroma_red        <= b[5];
    do @(posedge clk_i); while (!blocks_if.ready);
  endtask

  // Stop offering and wait until every predicted word has come out.
  task automatic settle();
    blocks_if.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending != 0);
    repeat (3) @(posedge clk_i);
  endtask

  // One register write; the caller lowers the enable after the last one.
  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
  endtask

  task automatic program_frame(input logic [SizeW-1:0] w, h, p,
                               input logic [CfgDataW-1:0] turn, order,
                               input bit set_turn, set_order);
    write_reg(CFG_SRC_WIDTH, w);
    write_reg(CFG_SRC_HEIGHT, h);
    write_reg(CFG_DST_PITCH, p);
    if (set_turn) write_reg(CFG_ROTATION, turn);
    if (set_order) write_reg(CFG_PACK_ORDER, order);
    cfg_we <= 1'b0;
  endtask

  // Result backpressure: changing patterns, and one long hold-off on request.
  initial begin : receiver
    int mode;
    int left;
    int tick;
    words_if.ready = 1'b0;
    mode = 0;
    left = 0;
    tick = 0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (stall_now && !stall_done) begin
        words_if.ready <= 1'b0;
        repeat (LongStall) @(posedge clk_i);
        stall_done = 1'b1;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(16, 160);
        end
        left--;
        case (mode)
          0:       words_if.ready <= 1'b1;
          1:       words_if.ready <= 1'($urandom_range(0, 1));
          2:       words_if.ready <= ($urandom_range(0, 5) != 0);
          default: words_if.ready <= (tick % 4 != 3);
        endcase
      end
    end
  end

  // End the run when nothing moves for too long.
  initial begin : watchdog
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((blocks_if.valid && blocks_if.ready) || (words_if.valid && words_if.ready) || cfg_we)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    rot_e             turns [4];
    logic [PackW-1:0] orders [4];
    int               sent;
    int               cp;
    int               rp;
    int               frame_items;
    logic [SizeW-1:0] p;

    turns  = '{ROT_0, ROT_90, ROT_180, ROT_270};
    orders = '{PACK_U_YA_V_YB, PACK_YB_V_YA_U, PACK_YA_V_YB_U, PackUnused};
    rst_ni    = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_SRC_WIDTH;
    cfg_data  = '0;
    blocks_if.valid             = 1'b0;
    blocks_if.luma_top_left     = '0;
    blocks_if.luma_top_right    = '0;
    blocks_if.luma_bottom_left  = '0;
    blocks_if.luma_bottom_right = '0;
    blocks_if.chroma_blue       = '0;
    blocks_if.chroma_red        = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Default frame straight out of reset, with the pixel extremes.
    offer('0);
    offer('1);
    settle();

    // Every rotation and byte order on a frame of two blocks.
    for (int r = 0; r < 4; r++) begin
      program_frame(12'd4, 12'd2, 12'd6, CfgDataW'(turns[r]), CfgDataW'(orders[r]),
                    1'b1, 1'b1);
      repeat (2) offer(random_block());
      settle();
    end

    // Zero sizes act as one pair; with no pitch the half-turn start wraps below zero.
    program_frame('0, '0, '0, CfgDataW'(ROT_180), CfgDataW'(PACK_YB_V_YA_U), 1'b1, 1'b1);
    repeat (2) offer(random_block());
    settle();

    // Odd and oversized sizes clamp, the quarter-turn start wraps, and the frame
    // is left unfinished so the next write restarts it.
    program_frame('1, 12'd5, '1, CfgDataW'(ROT_90), CfgDataW'(PACK_YA_V_YB_U), 1'b1, 1'b1);
    repeat (3) offer(random_block());
    settle();

    // Random frames, mostly whole ones, some cut short or oversized.
    sent = 0;
    while (sent < NumItems) begin
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1)) begin
          cp = $urandom_range(1, 3);
          rp = $urandom_range(300, MaxDimDefault / 2);
        end else begin
          cp = $urandom_range(300, MaxDimDefault / 2);
          rp = $urandom_range(1, 3);
        end
        frame_items = $urandom_range(5, 40);
      end else begin
        cp = $urandom_range(1, 8);
        rp = $urandom_range(1, 6);
        frame_items = cp * rp * $urandom_range(1, 3);
        if ($urandom_range(0, 3) == 0) frame_items = $urandom_range(1, frame_items);
      end
      case ($urandom_range(0, 5))
        0:       p = '0;
        1:       p = '1;
        2:       p = SizeW'($urandom);
        default: p = SizeW'($urandom_range(0, 48));
      endcase
      program_frame(size_for(cp), size_for(rp), p, CfgDataW'($urandom), CfgDataW'($urandom),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));

      // The first batch runs into a long result hold-off so the core backs up.
      if (sent == 0) begin
        stall_now = 1'b1;
        frame_items += 24;
      end
      repeat (frame_items) offer(random_block());
      sent += frame_items;
      settle();
    end

    repeat (Drain) @(posedge clk_i);
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
